// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they expand to nothing when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// File: rtl/ela_pkg.sv
// ----------------------------------------------------------------------------
// ela_pkg
// Shared types and constants of the echoing line assembler.
// ----------------------------------------------------------------------------
package ela_pkg;

	localparam int unsigned LINE_CAP_DEF = 40;
	localparam logic [7:0]  CR_CODE      = 8'd13;

	typedef enum logic [1:0] {
		KIND_ECHO = 2'd0,
		KIND_LINE = 2'd1,
		KIND_TERM = 2'd2
	} kind_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // capture the incoming beat
		logic store;      // write held char at fill position, bump fill
		logic load_echo;  // output register <= echo of held char
		logic rd;         // read line store at replay index
		logic load_line;  // output register <= read data, bump index
		logic load_term;  // output register <= terminator, clear fill/index
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_cr;
		logic full;
		logic empty;
		logic idx_last;
		logic slot_free;
	} dp_sts_t;

endpackage

// File: rtl/ela_rx_if.sv
// ----------------------------------------------------------------------------
// ela_rx_if
// Receive channel: one character per beat.
// ----------------------------------------------------------------------------
interface ela_rx_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/ela_res_if.sv
// ----------------------------------------------------------------------------
// ela_res_if
// Result channel: echo, line character or terminator per beat.
// ----------------------------------------------------------------------------
interface ela_res_if;
	logic           valid;
	logic           ready;
	ela_pkg::kind_t kind;
	logic [7:0]     data;
	logic           last;

	modport source (output valid, output kind, output data, output last, input ready);
	modport sink   (input valid, input kind, input data, input last, output ready);
endinterface

// File: rtl/echoing_line_assembler_unit.sv
// ----------------------------------------------------------------------------
// echoing_line_assembler_unit
// Terminal line buffer with echo: assembles carriage-return-ended lines.
// ----------------------------------------------------------------------------
// Each received character is caught in a one-beat holding register, so rx is
// ready again as soon as the held character is dealt with, even while a
// result still waits in the output register. Any character other than a
// carriage return, the zero byte included, is stored and echoed (one beat,
// kind ECHO, last set). The echo beat passes from the holding register to
// the output register once that register is free, and no new character is
// taken while one is held. Once LINE_CAP-1 characters are stored, further
// characters are dropped with no beat. A carriage return is not stored or
// echoed: it replays the n stored characters as LINE beats and then sends
// one TERM beat (data 0, last set). Each LINE beat is read through the line
// store's single registered read port and then loaded into the one output
// register, and no character is taken during the replay. The fill count
// then returns to zero. The store needs no clearing after reset: only
// written entries are ever replayed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module echoing_line_assembler_unit #(
	parameter int unsigned LINE_CAP = ela_pkg::LINE_CAP_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ela_rx_if.sink    rx,
	ela_res_if.source res
);

	ela_pkg::ctrl_cmd_t cmd;
	ela_pkg::dp_sts_t   sts;
	logic               out_load;
	logic               term_shown;

	// sequencing of each held character
	ela_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// store, counters and output register
	ela_dp #(
		.LINE_CAP (LINE_CAP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx.rx_byte),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (res.valid),
		.out_kind  (res.kind),
		.out_data  (res.data),
		.out_last  (res.last)
	);

	assign out_load   = cmd.load_echo || cmd.load_line || cmd.load_term;
	assign term_shown = res.valid && res.last && (res.kind == ela_pkg::KIND_TERM) && sts.empty;

	// a beat is never loaded over one that has not been taken
	`ASSERT_NEVER(a_no_overwrite, clk, arst_n, out_load && res.valid && !res.ready, "beat overwritten")
	// only one kind of output load per cycle
	`ASSERT_PROP(a_one_load, clk, arst_n, $onehot0({cmd.load_echo, cmd.load_line, cmd.load_term}), "two loads")
	// terminator shows up next cycle, marked last, and the line is emptied
	`ASSERT_PROP(a_term_out, clk, arst_n, cmd.load_term |=> term_shown, "terminator not presented")
	// nothing is stored into a full line
	`ASSERT_NEVER(a_no_overfill, clk, arst_n, cmd.store && sts.full, "store written past capacity")

endmodule

// File: rtl/ela_dp.sv
// ----------------------------------------------------------------------------
// ela_dp
// Datapath: input holding register, line store, fill/replay counters and
// the output register.
// ----------------------------------------------------------------------------
module ela_dp #(
	parameter int unsigned LINE_CAP = ela_pkg::LINE_CAP_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           rx_byte,
	input  logic                 out_ready,
	input  ela_pkg::ctrl_cmd_t   cmd,
	output ela_pkg::dp_sts_t     sts,
	output logic                 out_valid,
	output ela_pkg::kind_t       out_kind,
	output logic [7:0]           out_data,
	output logic                 out_last
);

	localparam int unsigned IDX_W = $clog2(LINE_CAP);

	logic [7:0]       rx_q;
	logic [7:0]       mem_q [LINE_CAP];
	logic [7:0]       rd_data_q;
	logic [IDX_W-1:0] fill_q;
	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	ela_pkg::kind_t   kind_q;
	logic [7:0]       data_q;
	logic             last_q;

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			rx_q <= rx_byte;
		end
		if (cmd.store) begin
			mem_q[fill_q] <= rx_q;
		end
		if (cmd.rd) begin
			rd_data_q <= mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else if (cmd.load_term) begin
			fill_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.store) begin
				fill_q <= fill_q + IDX_W'(1);
			end
			if (cmd.load_line) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// single output slot; a load only happens when the slot is free
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_echo || cmd.load_line || cmd.load_term) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_echo) begin
			kind_q <= ela_pkg::KIND_ECHO;
			data_q <= rx_q;
			last_q <= 1'b1;
		end else if (cmd.load_line) begin
			kind_q <= ela_pkg::KIND_LINE;
			data_q <= rd_data_q;
			last_q <= 1'b0;
		end else if (cmd.load_term) begin
			kind_q <= ela_pkg::KIND_TERM;
			data_q <= '0;
			last_q <= 1'b1;
		end
	end

	assign sts.is_cr     = (rx_q == ela_pkg::CR_CODE);
	assign sts.full      = (fill_q == IDX_W'(LINE_CAP - 1));
	assign sts.empty     = (fill_q == '0);
	assign sts.idx_last  = ((idx_q + IDX_W'(1)) == fill_q);
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_kind  = kind_q;
	assign out_data  = data_q;
	assign out_last  = last_q;

endmodule

// File: rtl/ela_ctrl.sv
// ----------------------------------------------------------------------------
// ela_ctrl
// Controller: sequences echo, drop and line replay for each held character.
// ----------------------------------------------------------------------------
module ela_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_ready,
	input  ela_pkg::dp_sts_t   sts,
	output ela_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_EMIT,
		ST_TERM
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   pend_q;
	logic   done;

	always_comb begin
		cmd     = '0;
		done    = 1'b0;
		state_d = state_q;
		cmd.take = rx_valid && !pend_q;
		unique case (state_q)
			ST_IDLE: begin
				if (pend_q && sts.slot_free) begin
					if (sts.is_cr) begin
						if (sts.empty) begin
							cmd.load_term = 1'b1;
							done          = 1'b1;
						end else begin
							cmd.rd  = 1'b1;
							state_d = ST_EMIT;
						end
					end else begin
						cmd.store     = !sts.full;
						cmd.load_echo = !sts.full;
						done          = 1'b1;
					end
				end
			end
			ST_READ: begin
				cmd.rd  = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.slot_free) begin
					cmd.load_line = 1'b1;
					state_d       = sts.idx_last ? ST_TERM : ST_READ;
				end
			end
			ST_TERM: begin
				if (sts.slot_free) begin
					cmd.load_term = 1'b1;
					done          = 1'b1;
					state_d       = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.take) begin
				pend_q <= 1'b1;
			end else if (done) begin
				pend_q <= 1'b0;
			end
		end
	end

	assign rx_ready = !pend_q;

endmodule
